// ===== rtl/aafc_pkg.sv =====
// Shared types and constants for the axis-aligned box frustum culling block.
// Depends on nothing; every other file in rtl/ but aafc_vis_if refers to it by scoped names.
`default_nettype none

package aafc_pkg;

  // Coordinate width of the box fields, signed Q8.8 at the default.
  localparam int COORD_WIDTH = 16;
  // Plane coefficients are signed Q8.8, four of them packed in one register.
  localparam int COEF_WIDTH  = 16;
  localparam int PLANE_WIDTH = 4 * COEF_WIDTH;
  localparam int PLANE_COUNT = 6;
  // Configuration index width; indices above the plane list are ignored.
  localparam int CFG_IDX_WIDTH = 3;

  // Product of one coefficient and one coordinate, Q16.16.
  localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;
  // Six product terms plus the aligned offset need three more bits.
  localparam int SUM_WIDTH  = PROD_WIDTH + 3;
  // The offset d is moved from Q8.8 to Q16.16.
  localparam int D_SHIFT    = 8;

  // Register indices of the configuration port.
  localparam logic [CFG_IDX_WIDTH-1:0] LEFT_PLANE_IDX   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] RIGHT_PLANE_IDX  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] TOP_PLANE_IDX    = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] BOTTOM_PLANE_IDX = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] NEAR_PLANE_IDX   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] FAR_PLANE_IDX    = 3'd5;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [COORD_WIDTH-1:0] coord_mag_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic        [COEF_WIDTH-1:0]  coef_mag_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic        [PROD_WIDTH-1:0]  uprod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic [CFG_IDX_WIDTH-1:0]      cfg_idx_t;

  // Packed plane register: a in the low slot, d in the high slot.
  typedef struct packed {
    coef_t d;
    coef_t c;
    coef_t b;
    coef_t a;
  } plane_t;

  // One box as it travels down the row of cells.
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t hx;
    coord_t hy;
    coord_t hz;
  } box_t;

  // Box plus the running verdict of the planes already passed.
  typedef struct packed {
    box_t box;
    logic culled;
  } tok_t;

endpackage

`default_nettype wire

// ===== rtl/aafc_box_if.sv =====
// Valid/ready channel carrying one box (centre and half extents) per beat.
// Depends on aafc_pkg for the coordinate type.
`default_nettype none

interface aafc_box_if;
  logic            valid;
  logic            ready;
  aafc_pkg::coord_t center_x;
  aafc_pkg::coord_t center_y;
  aafc_pkg::coord_t center_z;
  aafc_pkg::coord_t half_x;
  aafc_pkg::coord_t half_y;
  aafc_pkg::coord_t half_z;

  modport source (output valid, output center_x, output center_y, output center_z,
                  output half_x, output half_y, output half_z, input ready);
  modport sink   (input valid, input center_x, input center_y, input center_z,
                  input half_x, input half_y, input half_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/aafc_vis_if.sv =====
// Valid/ready channel carrying one visibility verdict per beat.
// Depends on nothing.
`default_nettype none

interface aafc_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, output visible, input ready);
  modport sink   (input valid, input visible, output ready);
endinterface

`default_nettype wire

// ===== rtl/aafc_cfg_if.sv =====
// Configuration write channel: register index and 64-bit data per beat.
// Depends on aafc_pkg for the index and plane widths.
`default_nettype none

interface aafc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  aafc_pkg::cfg_idx_t                   index;
  logic [aafc_pkg::PLANE_WIDTH-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/aabb_frustum_cull.sv =====
// Top level of the axis-aligned box frustum culling block.
// Depends on aafc_pkg, the three channel interfaces and aafc_cell.
//
// Usage:
//   in_box  : one box per beat, centre and half extents in signed Q8.8.
//   out_vis : one verdict per box, in order; visible = 0 means some plane
//             has all eight corners strictly on its negative side.
//   cfg     : plane writes, index 0 left, 1 right, 2 top, 3 bottom, 4 near,
//             5 far; each beat carries a, b, c, d packed from bit 0 upwards.
//             Indices 6 and 7 are ignored. cfg.ready is always high, and
//             planes should only be written while no box is in flight.
// Each box passes six plane cells in a row, each with a product stage and a
// sum stage. Throughput is one box per cycle while out_vis.ready is high,
// set by each cell holding its own plane and multipliers.
// Reset clears all planes to zero, which never cull, and empties the row.
// When the receiver stalls, the row keeps accepting boxes until every stage
// holds one; then in_box.ready drops until out_vis beats are taken.
`default_nettype none

module aabb_frustum_cull (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aafc_box_if.sink   in_box,
  aafc_vis_if.source out_vis,
  aafc_cfg_if.sink   cfg
);

  localparam int N = aafc_pkg::PLANE_COUNT;

  logic [N:0]           row_valid;
  logic [N:0]           row_ready;
  aafc_pkg::tok_t       row_tok [N+1];
  logic [N-1:0]         plane_we;

  // Configuration writes are always taken; the index decoded here selects the cell that loads.
  assign cfg.ready = 1'b1;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      plane_we[i] = cfg.valid && (cfg.index == aafc_pkg::cfg_idx_t'(i));
    end
  end

  // Entry of the row: a fresh box starts out not culled.
  always_comb begin
    row_tok[0].box.cx = in_box.center_x;
    row_tok[0].box.cy = in_box.center_y;
    row_tok[0].box.cz = in_box.center_z;
    row_tok[0].box.hx = in_box.half_x;
    row_tok[0].box.hy = in_box.half_y;
    row_tok[0].box.hz = in_box.half_z;
    row_tok[0].culled = 1'b0;
  end

  assign row_valid[0] = in_box.valid;
  assign in_box.ready = row_ready[0];

  // The row of plane cells, one per configured plane.
  for (genvar g = 0; g < N; g++) begin : g_cell
    aafc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .plane_we    (plane_we[g]),
      .plane_wdata (cfg.data),
      .up_valid    (row_valid[g]),
      .up_ready    (row_ready[g]),
      .up_tok      (row_tok[g]),
      .dn_valid    (row_valid[g+1]),
      .dn_ready    (row_ready[g+1]),
      .dn_tok      (row_tok[g+1])
    );
  end

  // Exit of the row: the last cell's stage register is the output register.
  assign out_vis.valid   = row_valid[N];
  assign out_vis.visible = !row_tok[N].culled;
  assign row_ready[N]    = out_vis.ready;

endmodule

`default_nettype wire

// ===== rtl/aafc_cell.sv =====
// One plane cell of the culling row: holds one plane and tests each passing box.
// Two pipeline stages (products, then sum and sign). Depends on aafc_pkg.
`default_nettype none

module aafc_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             plane_we,
  input  wire logic [aafc_pkg::PLANE_WIDTH-1:0] plane_wdata,
  input  wire logic                             up_valid,
  output      logic                             up_ready,
  input  wire aafc_pkg::tok_t                   up_tok,
  output      logic                             dn_valid,
  input  wire logic                             dn_ready,
  output      aafc_pkg::tok_t                   dn_tok
);

  aafc_pkg::plane_t plane_r;

  // Plane register, loaded from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (plane_we) begin
      plane_r <= aafc_pkg::plane_t'(plane_wdata);
    end
  end

  // The farthest corner along the plane normal gives the largest distance:
  // a*cx + |a|*|hx| per axis. All corners are negative exactly when it is.
  aafc_pkg::coef_mag_t  mag_a, mag_b, mag_c;
  aafc_pkg::coord_mag_t mag_hx, mag_hy, mag_hz;

  always_comb begin
    mag_a  = plane_r.a[aafc_pkg::COEF_WIDTH-1] ? aafc_pkg::coef_mag_t'(-plane_r.a)
                                               : aafc_pkg::coef_mag_t'(plane_r.a);
    mag_b  = plane_r.b[aafc_pkg::COEF_WIDTH-1] ? aafc_pkg::coef_mag_t'(-plane_r.b)
                                               : aafc_pkg::coef_mag_t'(plane_r.b);
    mag_c  = plane_r.c[aafc_pkg::COEF_WIDTH-1] ? aafc_pkg::coef_mag_t'(-plane_r.c)
                                               : aafc_pkg::coef_mag_t'(plane_r.c);
    mag_hx = up_tok.box.hx[aafc_pkg::COORD_WIDTH-1] ?
             aafc_pkg::coord_mag_t'(-up_tok.box.hx) : aafc_pkg::coord_mag_t'(up_tok.box.hx);
    mag_hy = up_tok.box.hy[aafc_pkg::COORD_WIDTH-1] ?
             aafc_pkg::coord_mag_t'(-up_tok.box.hy) : aafc_pkg::coord_mag_t'(up_tok.box.hy);
    mag_hz = up_tok.box.hz[aafc_pkg::COORD_WIDTH-1] ?
             aafc_pkg::coord_mag_t'(-up_tok.box.hz) : aafc_pkg::coord_mag_t'(up_tok.box.hz);
  end

  // Stage one: six independent products.
  aafc_pkg::prod_t  s1_ax_nxt, s1_by_nxt, s1_cz_nxt;
  aafc_pkg::uprod_t s1_ex_nxt, s1_ey_nxt, s1_ez_nxt;

  always_comb begin
    s1_ax_nxt = aafc_pkg::prod_t'(plane_r.a) * aafc_pkg::prod_t'(up_tok.box.cx);
    s1_by_nxt = aafc_pkg::prod_t'(plane_r.b) * aafc_pkg::prod_t'(up_tok.box.cy);
    s1_cz_nxt = aafc_pkg::prod_t'(plane_r.c) * aafc_pkg::prod_t'(up_tok.box.cz);
    s1_ex_nxt = aafc_pkg::uprod_t'(mag_a) * aafc_pkg::uprod_t'(mag_hx);
    s1_ey_nxt = aafc_pkg::uprod_t'(mag_b) * aafc_pkg::uprod_t'(mag_hy);
    s1_ez_nxt = aafc_pkg::uprod_t'(mag_c) * aafc_pkg::uprod_t'(mag_hz);
  end

  logic             s1_valid_r;
  aafc_pkg::tok_t   s1_tok_r;
  aafc_pkg::prod_t  s1_ax_r, s1_by_r, s1_cz_r;
  aafc_pkg::uprod_t s1_ex_r, s1_ey_r, s1_ez_r;

  // Stage two: exact sum with the aligned offset; a negative sum culls.
  aafc_pkg::sum_t   dist_max;
  aafc_pkg::tok_t   s2_tok_nxt;

  always_comb begin
    dist_max = aafc_pkg::sum_t'(s1_ax_r) + aafc_pkg::sum_t'(s1_by_r)
             + aafc_pkg::sum_t'(s1_cz_r)
             + aafc_pkg::sum_t'($signed({1'b0, s1_ex_r}))
             + aafc_pkg::sum_t'($signed({1'b0, s1_ey_r}))
             + aafc_pkg::sum_t'($signed({1'b0, s1_ez_r}))
             + aafc_pkg::sum_t'($signed({plane_r.d, {aafc_pkg::D_SHIFT{1'b0}}}));
    s2_tok_nxt        = s1_tok_r;
    s2_tok_nxt.culled = s1_tok_r.culled | dist_max[aafc_pkg::SUM_WIDTH-1];
  end

  logic           s2_valid_r;
  aafc_pkg::tok_t s2_tok_r;
  logic           s1_ready, s2_ready;

  // Each stage moves on when it is empty or its beat leaves downstream.
  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;
  assign dn_valid = s2_valid_r;
  assign dn_tok   = s2_tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= up_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_tok_r <= up_tok;
      s1_ax_r  <= s1_ax_nxt;
      s1_by_r  <= s1_by_nxt;
      s1_cz_r  <= s1_cz_nxt;
      s1_ex_r  <= s1_ex_nxt;
      s1_ey_r  <= s1_ey_nxt;
      s1_ez_r  <= s1_ez_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_tok_r <= s2_tok_nxt;
    end
  end

endmodule

`default_nettype wire
